// ----- design/spn_pkg.sv -----
// ----------------------------------------------------------------------------
// spn_pkg
// Shared types, constants and character classifiers for the speech text
// normalizer.
// ----------------------------------------------------------------------------
package spn_pkg;

  // Code point width and held whitespace store sizing.
  localparam int CP_W       = 21;
  localparam int HOLD_DEPTH = 8;
  localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  // Characters with special handling.
  localparam logic [CP_W-1:0] CP_TAB       = 21'h00009;
  localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
  localparam logic [CP_W-1:0] CP_CR        = 21'h0000D;
  localparam logic [CP_W-1:0] CP_SPACE     = 21'h00020;
  localparam logic [CP_W-1:0] CP_LPAREN    = 21'h00028;
  localparam logic [CP_W-1:0] CP_RPAREN    = 21'h00029;
  localparam logic [CP_W-1:0] CP_FW_LPAREN = 21'h0FF08;
  localparam logic [CP_W-1:0] CP_FW_RPAREN = 21'h0FF09;
  localparam logic [CP_W-1:0] CP_CJK_LOW   = 21'h04E00;
  localparam logic [CP_W-1:0] CP_CJK_HIGH  = 21'h09FFF;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HELD,
    S_CHAR,
    S_CLOSE
  } state_t;

  // What an accepted item still needs after it is taken.
  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_JOIN,
    CLS_FLUSH,
    CLS_END_SP
  } item_cls_t;

  // Datapath operation for the current cycle.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOKEN,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    logic take;
    op_t  op;
    logic from_held;
  } cmd_t;

  typedef struct packed {
    logic      out_free;
    item_cls_t cls;
    logic      step_done;
    logic      idx_last;
  } status_t;

  // Unicode White_Space set.
  function automatic logic is_ws(input logic [CP_W-1:0] c);
    logic r;
    r = (c >= 21'h00009 && c <= 21'h0000D) || c == 21'h00020 || c == 21'h00085 ||
        c == 21'h000A0 || c == 21'h01680 || (c >= 21'h02000 && c <= 21'h0200A) ||
        c == 21'h02028 || c == 21'h02029 || c == 21'h0202F || c == 21'h0205F ||
        c == 21'h03000;
    return r;
  endfunction

  function automatic logic is_cjk(input logic [CP_W-1:0] c);
    return (c >= CP_CJK_LOW) && (c <= CP_CJK_HIGH);
  endfunction

  // Fullwidth parentheses fold to ASCII.
  function automatic logic [CP_W-1:0] map_paren(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    r = c;
    if (c == CP_FW_LPAREN) begin
      r = CP_LPAREN;
    end else if (c == CP_FW_RPAREN) begin
      r = CP_RPAREN;
    end
    return r;
  endfunction

endpackage

// ----- design/spn_ctrl.sv -----
// ----------------------------------------------------------------------------
// spn_ctrl
// Controller state machine: accepts items, steps through held whitespace,
// the pending character and the closing result.
// ----------------------------------------------------------------------------
module spn_ctrl import spn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  // An item is taken only in idle with room in the output register.
  assign take = (state == S_IDLE) && status.out_free && in_valid;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (status.cls)
            CLS_FLUSH:  state_next = S_HELD;
            CLS_JOIN:   state_next = S_CHAR;
            CLS_END_SP: state_next = S_CLOSE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_HELD: begin
        if (status.step_done && status.idx_last) begin
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        if (status.step_done) begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall      = !((state == S_IDLE) && status.out_free);
    cmd.take      = take;
    cmd.op        = OP_NONE;
    cmd.from_held = 1'b0;
    case (state)
      S_HELD: begin
        cmd.op        = OP_TOKEN;
        cmd.from_held = 1'b1;
      end
      S_CHAR:  cmd.op = OP_TOKEN;
      S_CLOSE: cmd.op = OP_CLOSE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- design/spn_datapath.sv -----
// ----------------------------------------------------------------------------
// spn_datapath
// Text state, held whitespace store, one-token normalizing engine and the
// output register.
// ----------------------------------------------------------------------------
module spn_datapath import spn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output status_t         status,
  input  logic [CP_W-1:0] code_point,
  input  logic            part,
  input  logic            end_marker,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_point,
  output logic            has_char,
  output logic            last,
  output logic            overflow
);

  // Text state.
  logic                  in_content;
  logic                  ref_nonempty;
  logic                  current_part;
  logic [HOLD_CNT_W-1:0] held_count;
  logic [CP_W-1:0]       prev_char;
  logic                  prev_valid;
  logic                  overflow_seen;
  logic                  pending;
  logic [HOLD_IDX_W-1:0] idx;
  logic [CP_W-1:0]       cp_reg;
  logic [CP_W-1:0]       held_run [HOLD_DEPTH];

  // Item decode.
  logic                  part_sw;
  logic                  ie;
  logic [HOLD_CNT_W-1:0] hc_eff;
  logic                  part_eff;
  logic                  ref_ne_eff;
  logic                  in_ws;
  logic [CP_W-1:0]       cp_map;
  logic                  prev_cjk;
  logic                  end_sp;
  item_cls_t             cls;

  // Token engine.
  logic [CP_W-1:0]       tok;
  logic                  tok_drop;
  logic                  tok_sp;
  logic                  sp_ok;
  logic                  step_done;
  logic                  idx_last;
  logic                  out_free;

  // Emission.
  logic                  emit;
  logic [CP_W-1:0]       e_point;
  logic                  e_has;
  logic                  e_last;

  assign out_free = !out_valid || !out_stall;
  assign prev_cjk = prev_valid && is_cjk(prev_char);

  // Classify the item at the input, including a switch to the target part.
  always_comb begin
    part_sw    = !end_marker && !current_part && part;
    ie         = part_sw ? 1'b0 : in_content;
    hc_eff     = part_sw ? '0 : held_count;
    part_eff   = current_part | part_sw;
    ref_ne_eff = part_sw ? in_content : ref_nonempty;
    in_ws      = is_ws(code_point);
    cp_map     = map_paren(code_point);
    end_sp     = (current_part ? ref_nonempty : in_content) &&
                 !(current_part && in_content) && !prev_cjk;
    if (end_marker) begin
      cls = end_sp ? CLS_END_SP : CLS_DONE;
    end else if (in_ws) begin
      cls = CLS_DONE;
    end else if (!ie) begin
      cls = (part_eff && ref_ne_eff) ? CLS_JOIN : CLS_DONE;
    end else begin
      cls = (hc_eff != '0) ? CLS_FLUSH : CLS_DONE;
    end
  end

  // One token a step: held whitespace or the latched character.
  always_comb begin
    tok       = cmd.from_held ? held_run[idx] : cp_reg;
    tok_drop  = (tok == CP_CR) || (tok == CP_LF);
    tok_sp    = (tok == CP_SPACE) || (tok == CP_TAB);
    sp_ok     = pending && !prev_cjk && !is_cjk(tok);
    step_done = tok_drop || tok_sp || (out_free && !sp_ok);
    idx_last  = (HOLD_CNT_W'(idx) + 1'b1) == held_count;
  end

  assign status.out_free  = out_free;
  assign status.cls       = cls;
  assign status.step_done = step_done;
  assign status.idx_last  = idx_last;

  // Select what goes to the output register this cycle.
  always_comb begin
    emit    = 1'b0;
    e_point = cp_map;
    e_has   = 1'b1;
    e_last  = 1'b0;
    if (cmd.take) begin
      if (end_marker) begin
        emit    = 1'b1;
        e_point = end_sp ? CP_SPACE : '0;
        e_has   = end_sp;
        e_last  = !end_sp;
      end else if (!in_ws && cls == CLS_DONE) begin
        emit = 1'b1;
      end
    end else begin
      case (cmd.op)
        OP_TOKEN: begin
          emit    = !tok_drop && !tok_sp && out_free;
          e_point = sp_ok ? CP_SPACE : tok;
        end
        OP_CLOSE: begin
          emit    = out_free;
          e_point = '0;
          e_has   = 1'b0;
          e_last  = 1'b1;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_point <= e_point;
      has_char  <= e_has;
      last      <= e_last;
      overflow  <= overflow_seen;
    end
  end

  // Held whitespace store.
  always_ff @(posedge clk) begin
    if (cmd.take && !end_marker && in_ws && ie &&
        hc_eff < HOLD_CNT_W'(HOLD_DEPTH)) begin
      held_run[hc_eff[HOLD_IDX_W-1:0]] <= code_point;
    end
  end

  // Text state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_content    <= 1'b0;
      ref_nonempty  <= 1'b0;
      current_part  <= 1'b0;
      held_count    <= '0;
      prev_char     <= '0;
      prev_valid    <= 1'b0;
      overflow_seen <= 1'b0;
      pending       <= 1'b0;
      idx           <= '0;
    end else if (cmd.take) begin
      cp_reg  <= cp_map;
      idx     <= '0;
      pending <= (cls == CLS_JOIN);
      if (end_marker) begin
        if (!end_sp) begin
          in_content    <= 1'b0;
          ref_nonempty  <= 1'b0;
          current_part  <= 1'b0;
          held_count    <= '0;
          prev_char     <= '0;
          prev_valid    <= 1'b0;
          overflow_seen <= 1'b0;
        end
      end else begin
        current_part <= part_eff;
        ref_nonempty <= ref_ne_eff;
        held_count   <= hc_eff;
        if (in_ws) begin
          in_content <= ie;
          if (ie) begin
            if (hc_eff < HOLD_CNT_W'(HOLD_DEPTH)) begin
              held_count <= hc_eff + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end else begin
          in_content <= 1'b1;
          if (cls == CLS_DONE) begin
            prev_char  <= cp_map;
            prev_valid <= 1'b1;
          end
        end
      end
    end else begin
      case (cmd.op)
        OP_TOKEN: begin
          if (tok_sp) begin
            pending <= 1'b1;
          end else if (!tok_drop && out_free) begin
            pending <= 1'b0;
            if (!sp_ok) begin
              prev_char  <= tok;
              prev_valid <= 1'b1;
            end
          end
          if (step_done && cmd.from_held) begin
            idx <= idx + 1'b1;
            if (idx_last) begin
              held_count <= '0;
            end
          end
        end
        OP_CLOSE: begin
          if (out_free) begin
            in_content    <= 1'b0;
            ref_nonempty  <= 1'b0;
            current_part  <= 1'b0;
            held_count    <= '0;
            prev_char     <= '0;
            prev_valid    <= 1'b0;
            overflow_seen <= 1'b0;
            pending       <= 1'b0;
          end
        end
        default: pending <= pending;
      endcase
    end
  end

endmodule

// ----- design/speech_text_normalizer.sv -----
// ----------------------------------------------------------------------------
// speech_text_normalizer
// Merges a reference transcript and a target text, given as code points,
// into one normalized text, one code point per output transfer.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_stall  | code_point, part, end_marker
//  output  | out_valid, out_stall| out_point, has_char, last, overflow
//
// A whitespace item or a character that needs no joining space and follows
// no held whitespace is finished when it is accepted. A character after a
// held run is accepted, then each held entry is stepped, then the character
// itself, with an extra step for each space emitted, all through the single
// token engine. A character that owes a joining space is accepted and then
// stepped, with an extra step when the space is emitted. An end marker is
// finished when accepted, or followed by a closing step when a space is owed.
// Reset is synchronous on rst; no clearing pass is needed. A stalled output
// register also holds off input transfers.
module speech_text_normalizer import spn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CP_W-1:0] code_point,
  input  logic            part,
  input  logic            end_marker,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_point,
  output logic            has_char,
  output logic            last,
  output logic            overflow
);

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  spn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // State, store and output register.
  spn_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .code_point (code_point),
    .part       (part),
    .end_marker (end_marker),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_point  (out_point),
    .has_char   (has_char),
    .last       (last),
    .overflow   (overflow)
  );

endmodule

// ----- design/spn_checker.sv -----
// ----------------------------------------------------------------------------
// spn_checker
// Port-level checks of the speech text normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module spn_checker import spn_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CP_W-1:0] out_point,
  input logic            has_char,
  input logic            last,
  input logic            overflow
);

  logic ovf_armed;

  // Remember a transfer that reported overflow inside an unfinished text.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_armed <= 1'b0;
    end else if (out_valid && !out_stall) begin
      ovf_armed <= overflow && !last;
    end
  end

  // A stalled result holds its point and its last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_point) && $stable(last))
    else $error("stalled result changed");

  // The closing result carries no character.
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !has_char && out_point == '0)
    else $error("closing result carries a character");

  // Only the closing result is empty.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> last)
    else $error("empty result that is not the closing one");

  // Overflow stays flagged until the text closes.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && ovf_armed |-> overflow)
    else $error("overflow flag dropped inside a text");

  // No input transfer while a result waits on a stalled output.
  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

endmodule

bind speech_text_normalizer spn_checker u_spn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_point (out_point),
  .has_char  (has_char),
  .last      (last),
  .overflow  (overflow)
);

// ----- test/speech_text_normalizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speech_text_normalizer_tb
// Self-checking bench for the speech text normalizer. A directed opening
// covers trimming, joining, folding, CJK spacing and a cut whitespace run.
// Random texts with random content then follow. A behavioral predictor runs
// on every accepted input transfer, and the monitor compares every output
// transfer field by field against the oldest predicted result. Both channels
// idle at random, except for one calm stretch.
// ----------------------------------------------------------------------------
module speech_text_normalizer_tb;
  import spn_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 24;
  localparam int MAX_REPORTS = 30;

  // One input item and one normalized output character.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            prt;
    logic            endm;
  } text_item_t;

  typedef struct packed {
    logic [CP_W-1:0] pt;
    logic            has;
    logic            fin;
    logic            ovf;
  } norm_char_t;

  logic            clk        = 1'b0;
  logic            rst        = 1'b1;
  logic            in_valid   = 1'b0;
  logic [CP_W-1:0] code_point = '0;
  logic            part       = 1'b0;
  logic            end_marker = 1'b0;
  logic            out_stall  = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic [CP_W-1:0] out_point;
  logic            has_char;
  logic            last;
  logic            overflow;

  text_item_t text_q[$];
  norm_char_t chars_due[$];

  int cycle_count   = 0;
  int in_transfers  = 0;
  int out_transfers = 0;
  int texts_closed  = 0;
  int cut_texts     = 0;
  int err_count     = 0;
  int random_items  = 0;

  // Predictor state.
  logic            seen_visible = 1'b0;
  logic            ref_had_text = 1'b0;
  logic            in_target    = 1'b0;
  logic [CP_W-1:0] held_ws [HOLD_DEPTH];
  int              held_n       = 0;
  logic [CP_W-1:0] last_glyph   = '0;
  logic            last_ok      = 1'b0;
  logic            ws_cut       = 1'b0;
  logic            gap_owed     = 1'b0;

  wire calm = (in_transfers >= 140) && (in_transfers < 220);

  speech_text_normalizer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .part       (part),
    .end_marker (end_marker),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_point  (out_point),
    .has_char   (has_char),
    .last       (last),
    .overflow   (overflow)
  );

  always #10 clk = ~clk;

  // Character classes, written independently of the design.
  function automatic logic white(input logic [CP_W-1:0] c);
    logic r;
    case (c)
      21'h00020, 21'h00085, 21'h000A0, 21'h01680, 21'h02028, 21'h02029,
      21'h0202F, 21'h0205F, 21'h03000: r = 1'b1;
      default: r = (c inside {[21'h00009:21'h0000D]}) || (c inside {[21'h02000:21'h0200A]});
    endcase
    return r;
  endfunction

  function automatic logic ideograph(input logic [CP_W-1:0] c);
    return c >= CP_CJK_LOW && c <= CP_CJK_HIGH;
  endfunction

  task automatic push_char(input logic [CP_W-1:0] c, input logic has, input logic fin);
    norm_char_t entry;
    entry = '{pt: c, has: has, fin: fin, ovf: ws_cut};
    chars_due.insert(chars_due.size(), entry);
  endtask

  // Collapsing stage followed by the CJK spacing stage.
  task automatic collapse_feed(input logic [CP_W-1:0] c_in);
    logic [CP_W-1:0] c;
    c = c_in;
    if (c != CP_CR && c != CP_LF) begin
      if (c == CP_FW_LPAREN) begin
        c = CP_LPAREN;
      end else if (c == CP_FW_RPAREN) begin
        c = CP_RPAREN;
      end
      if (c == CP_SPACE || c == CP_TAB) begin
        gap_owed = 1'b1;
      end else begin
        if (gap_owed && !(last_ok && ideograph(last_glyph)) && !ideograph(c)) begin
          push_char(CP_SPACE, 1'b1, 1'b0);
        end
        gap_owed = 1'b0;
        push_char(c, 1'b1, 1'b0);
        last_glyph = c;
        last_ok = 1'b1;
      end
    end
  endtask

  // Works out the normalized characters caused by one accepted item.
  task automatic predict_item(input logic [CP_W-1:0] cp, input logic prt,
                              input logic endm);
    logic ref_ne;
    logic txt_had;
    gap_owed = 1'b0;
    if (endm) begin
      ref_ne  = in_target ? ref_had_text : seen_visible;
      txt_had = in_target && seen_visible;
      if (ref_ne && !txt_had && !(last_ok && ideograph(last_glyph))) begin
        push_char(CP_SPACE, 1'b1, 1'b0);
      end
      push_char('0, 1'b0, 1'b1);
      seen_visible = 1'b0;
      ref_had_text = 1'b0;
      in_target    = 1'b0;
      held_n       = 0;
      last_glyph   = '0;
      last_ok      = 1'b0;
      ws_cut       = 1'b0;
    end else begin
      if (!in_target && prt) begin
        ref_had_text = seen_visible;
        seen_visible = 1'b0;
        held_n       = 0;
        in_target    = 1'b1;
      end
      if (white(cp)) begin
        if (seen_visible) begin
          if (held_n < HOLD_DEPTH) begin
            held_ws[held_n] = cp;
            held_n++;
          end else begin
            ws_cut = 1'b1;
          end
        end
      end else begin
        if (!seen_visible) begin
          seen_visible = 1'b1;
          if (in_target && ref_had_text) begin
            collapse_feed(CP_SPACE);
          end
        end else begin
          for (int k = 0; k < held_n; k++) begin
            collapse_feed(held_ws[k]);
          end
          held_n = 0;
        end
        collapse_feed(cp);
      end
    end
  endtask

  // Random content: printable ASCII, blanks, line breaks, rare whitespace, CJK,
  // fullwidth parentheses and any code point at all.
  function automatic logic [CP_W-1:0] pick_char();
    int roll;
    logic [CP_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 36) begin
      c = CP_W'($urandom_range(21'h21, 21'h7E));
    end else if (roll < 50) begin
      c = CP_SPACE;
    end else if (roll < 57) begin
      c = CP_TAB;
    end else if (roll < 62) begin
      c = (roll % 2 == 0) ? CP_CR : CP_LF;
    end else if (roll < 69) begin
      case ($urandom_range(0, 11))
        0: c = 21'h0000B;
        1: c = 21'h0000C;
        2: c = 21'h00085;
        3: c = 21'h000A0;
        4: c = 21'h01680;
        5: c = CP_W'($urandom_range(21'h02000, 21'h0200A));
        6: c = 21'h02028;
        7: c = 21'h02029;
        8: c = 21'h0202F;
        9: c = 21'h0205F;
        default: c = 21'h03000;
      endcase
    end else if (roll < 82) begin
      case ($urandom_range(0, 5))
        0: c = CP_CJK_LOW - 21'd1;
        1: c = CP_CJK_LOW;
        2: c = CP_CJK_HIGH;
        3: c = CP_CJK_HIGH + 21'd1;
        default: c = CP_W'($urandom_range(CP_CJK_LOW, CP_CJK_HIGH));
      endcase
    end else if (roll < 87) begin
      c = (roll % 2 == 0) ? CP_FW_LPAREN : CP_FW_RPAREN;
    end else begin
      c = CP_W'($urandom_range(0, 21'h10FFFF));
    end
    return c;
  endfunction

  task automatic queue_item(input logic [CP_W-1:0] cp, input logic prt, input logic endm);
    text_item_t entry;
    entry = '{cp: cp, prt: prt, endm: endm};
    text_q.insert(text_q.size(), entry);
  endtask

  // Queues a whitespace run of HOLD_DEPTH - 2 to HOLD_DEPTH + 3 items, near or past the held store.
  task automatic queue_ws_run(input logic prt);
    int n;
    n = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 3);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: queue_item(CP_TAB, prt, 1'b0);
        1: queue_item(21'h03000, prt, 1'b0);
        default: queue_item(CP_SPACE, prt, 1'b0);
      endcase
    end
    random_items += n;
  endtask

  // One random text: reference, target, end marker.
  task automatic queue_text();
    int n_ref;
    int n_tgt;
    logic prt;
    n_ref = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
    n_tgt = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 14);
    for (int k = 0; k < n_ref; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        queue_ws_run(1'b0);
      end
      queue_item(pick_char(), 1'b0, 1'b0);
    end
    for (int k = 0; k < n_tgt; k++) begin
      // A stray reference bit after the target has begun.
      prt = (k > 0 && $urandom_range(0, 24) == 0) ? 1'b0 : 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        queue_ws_run(prt);
      end
      queue_item(pick_char(), prt, 1'b0);
    end
    queue_item(CP_W'($urandom_range(0, 21'h10FFFF)), 1'($urandom_range(0, 1)), 1'b1);
    random_items += n_ref + n_tgt + 1;
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || in_valid || chars_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Input driver: presents queued items and runs the predictor on each
  // accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(code_point, part, end_marker);
        in_transfers++;
      end
      if (!in_valid || !in_stall) begin
        if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          text_item_t nxt;
          nxt = text_q.pop_front();
          in_valid   <= 1'b1;
          code_point <= nxt.cp;
          part       <= nxt.prt;
          end_marker <= nxt.endm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure and comparison with the oldest
  // predicted character.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_transfers++;
        if (chars_due.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected transfer, got point %h has %b last %b ovf %b",
                     $time, out_point, has_char, last, overflow);
          end
        end else begin
          norm_char_t want;
          want = chars_due.pop_front();
          if (want.pt !== out_point || want.has !== has_char || want.fin !== last ||
              want.ovf !== overflow) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: expected point %h has %b last %b ovf %b, got %h %b %b %b",
                       $time, want.pt, want.has, want.fin, want.ovf,
                       out_point, has_char, last, overflow);
            end
          end
        end
        if (last === 1'b1) begin
          texts_closed++;
          if (overflow === 1'b1) begin
            cut_texts++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("speech_text_normalizer_tb: errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reference with leading blank, collapsing blanks, a fullwidth paren,
    // a dropped CR, a CJK end and a trailing held blank.
    queue_item(CP_SPACE, 1'b0, 1'b0);
    queue_item(21'h00041, 1'b0, 1'b0);
    queue_item(CP_TAB, 1'b0, 1'b0);
    queue_item(CP_SPACE, 1'b0, 1'b0);
    queue_item(CP_FW_LPAREN, 1'b0, 1'b0);
    queue_item(CP_CR, 1'b0, 1'b0);
    queue_item(CP_CJK_HIGH, 1'b0, 1'b0);
    queue_item(CP_SPACE, 1'b0, 1'b0);
    // Target with leading ideographic space, a CJK join and a run that
    // overfills the held store.
    queue_item(21'h03000, 1'b1, 1'b0);
    queue_item(CP_CJK_LOW, 1'b1, 1'b0);
    queue_item(21'h00085, 1'b1, 1'b0);
    for (int k = 0; k < HOLD_DEPTH - 1; k++) begin
      queue_item(CP_SPACE, 1'b1, 1'b0);
    end
    queue_item(CP_TAB, 1'b1, 1'b0);
    queue_item(CP_FW_RPAREN, 1'b1, 1'b0);
    // Reference bit after target, highest code point.
    queue_item(21'h10FFFF, 1'b0, 1'b0);
    queue_item(21'h10FFFF, 1'b1, 1'b1);
    // Nonempty reference with an empty target.
    queue_item(21'h00078, 1'b0, 1'b0);
    queue_item('0, 1'b0, 1'b1);

    // Hold off until everything so far has come out.
    wait_drained();

    while (random_items < 290) begin
      queue_text();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (chars_due.size() != 0) begin
      err_count++;
    end

    $display("Run covered %0d input and %0d output transfers over %0d texts,",
             in_transfers, out_transfers, texts_closed);
    $display("%0d of them with a whitespace run cut by the held store.", cut_texts);
    if (err_count == 0) begin
      $display("speech_text_normalizer_tb: clean");
    end else begin
      $display("speech_text_normalizer_tb: errors");
    end
    $finish;
  end

endmodule
